// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the position-hold controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TAPPH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tapph assertion failed");

// next-cycle implication, disabled during reset
`define TAPPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tapph assertion failed");

`endif

// ===== rtl/tapph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapph_pkg
// Types, constants and register codes of the position-hold controller.
// ----------------------------------------------------------------------------
package tapph_pkg;

  localparam int DISP_WIDTH_DEF = 24;
  localparam int GAIN_W         = 32;
  localparam int LIM_W          = 16;
  localparam int INTEG_W        = 26;
  localparam int ANGLE_W        = 12;
  localparam int ANGLE_MAX      = 1664;
  localparam int ACC_W          = 64;
  localparam int FRAC_SHIFT     = 16;
  localparam int LANE_STAGES    = 7;
  localparam int CNT_W          = 3;
  localparam int CFG_ADDR_W     = 5;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 3;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd32768;
  localparam logic signed [ACC_W-1:0] ACC_CLAMP  = 64'sh1000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] INNER_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] INNER_MIN  = 64'shFFFF_FFFF_8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_THR  = 3'd7;

  localparam logic signed [GAIN_W-1:0] RST_GAIN_P_X = 32'sd2949;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_I_X = 32'sd468;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_D_X = 32'sd2293760;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_P_Y = 32'sd2949;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_I_Y = 32'sd229;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_D_Y = 32'sd2464153;
  localparam logic [LIM_W-1:0]         RST_INTEG_LIM = 16'd50000;
  localparam logic [LIM_W-1:0]         RST_GROUND_THR = 16'd220;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p;
    logic signed [GAIN_W-1:0] i;
    logic signed [GAIN_W-1:0] d;
  } lane_gains_t;

  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctl_t;

endpackage

// ===== rtl/tapph_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapph_if
// Input and result channels of the position-hold controller.
// ----------------------------------------------------------------------------
interface tapph_in_if #(
  parameter int DISP_WIDTH = tapph_pkg::DISP_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [DISP_WIDTH-1:0]  disp_x;
  logic signed [DISP_WIDTH-1:0]  disp_y;
  logic [tapph_pkg::LIM_W-1:0]   distance;

  modport source (output valid, output disp_x, output disp_y, output distance, input ready);
  modport sink   (input valid, input disp_x, input disp_y, input distance, output ready);
endinterface

interface tapph_out_if #(
  parameter int DISP_WIDTH = tapph_pkg::DISP_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [tapph_pkg::ANGLE_W-1:0] angle_x;
  logic signed [tapph_pkg::ANGLE_W-1:0] angle_y;
  logic signed [DISP_WIDTH:0]         delta_x;
  logic signed [DISP_WIDTH:0]         delta_y;

  modport source (output valid, output angle_x, output angle_y, output delta_x,
                  output delta_y, input ready);
  modport sink   (input valid, input angle_x, input angle_y, input delta_x,
                  input delta_y, output ready);
endinterface

// ===== rtl/two_axis_position_hold_pid_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_position_hold_pid_unit
// Two-axis position-hold PID with clamped integrators and ground reset.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries x/y flow displacement (Q.8 cm) and a ground distance;
//   out_ch returns the x/y tilt commands (1/256 degree, within +/-6.5 deg)
//   and the x/y displacement differences. One result per input transfer.
//   The cfg_ port is APB: gains at byte 0..20, integrator limit at 24,
//   ground threshold at 28. Write only while no item is in flight.
//   Both axes run in their own lane of seven registered stages (integrator,
//   products, clamp, sum, round, gain product, saturate); the x and y lanes
//   share one sequencer, which takes one item at a time.
//   A new item is accepted only once the previous result has entered the
//   output register.
//   A finished result waits in the output register; a stalled receiver holds
//   it and the next item may still be accepted and computed, then waits.
//   Reset: gains and limits return to defaults, integrators and stored
//   displacements clear, no result is pending.
// ----------------------------------------------------------------------------
module two_axis_position_hold_pid_unit #(
  parameter int DISP_WIDTH = tapph_pkg::DISP_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tapph_in_if.sink                         in_ch,
  tapph_out_if.source                      out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tapph_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tapph_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tapph_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int LW = tapph_pkg::LIM_W;
  localparam int QW = tapph_pkg::ANGLE_W;

  tapph_pkg::lane_gains_t gains_x_r;
  tapph_pkg::lane_gains_t gains_y_r;
  logic [LW-1:0]          integ_limit_r;
  logic [LW-1:0]          ground_thr_r;

  logic [1:0]                    state_r;
  logic [1:0]                    state_nxt;
  logic [tapph_pkg::CNT_W-1:0]   cnt_r;
  logic [tapph_pkg::CNT_W-1:0]   cnt_nxt;

  logic                           accept;
  logic                           load;
  logic                           free;
  logic                           cfg_wr;
  logic [tapph_pkg::CFG_IDX_W-1:0] cfg_idx;
  tapph_pkg::lane_ctl_t           lane_ctl;

  logic signed [QW-1:0]        angle_x;
  logic signed [QW-1:0]        angle_y;
  logic signed [DISP_WIDTH:0]  delta_x;
  logic signed [DISP_WIDTH:0]  delta_y;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[tapph_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_x_r.p   <= tapph_pkg::RST_GAIN_P_X;
      gains_x_r.i   <= tapph_pkg::RST_GAIN_I_X;
      gains_x_r.d   <= tapph_pkg::RST_GAIN_D_X;
      gains_y_r.p   <= tapph_pkg::RST_GAIN_P_Y;
      gains_y_r.i   <= tapph_pkg::RST_GAIN_I_Y;
      gains_y_r.d   <= tapph_pkg::RST_GAIN_D_Y;
      integ_limit_r <= tapph_pkg::RST_INTEG_LIM;
      ground_thr_r  <= tapph_pkg::RST_GROUND_THR;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tapph_pkg::REG_GAIN_P_X:    gains_x_r.p   <= cfg_pwdata;
        tapph_pkg::REG_GAIN_I_X:    gains_x_r.i   <= cfg_pwdata;
        tapph_pkg::REG_GAIN_D_X:    gains_x_r.d   <= cfg_pwdata;
        tapph_pkg::REG_GAIN_P_Y:    gains_y_r.p   <= cfg_pwdata;
        tapph_pkg::REG_GAIN_I_Y:    gains_y_r.i   <= cfg_pwdata;
        tapph_pkg::REG_GAIN_D_Y:    gains_y_r.d   <= cfg_pwdata;
        tapph_pkg::REG_INTEG_LIMIT: integ_limit_r <= cfg_pwdata[LW-1:0];
        tapph_pkg::REG_GROUND_THR:  ground_thr_r  <= cfg_pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tapph_pkg::REG_GAIN_P_X:    cfg_prdata = gains_x_r.p;
      tapph_pkg::REG_GAIN_I_X:    cfg_prdata = gains_x_r.i;
      tapph_pkg::REG_GAIN_D_X:    cfg_prdata = gains_x_r.d;
      tapph_pkg::REG_GAIN_P_Y:    cfg_prdata = gains_y_r.p;
      tapph_pkg::REG_GAIN_I_Y:    cfg_prdata = gains_y_r.i;
      tapph_pkg::REG_GAIN_D_Y:    cfg_prdata = gains_y_r.d;
      tapph_pkg::REG_INTEG_LIMIT: cfg_prdata = tapph_pkg::CFG_DATA_W'(integ_limit_r);
      tapph_pkg::REG_GROUND_THR:  cfg_prdata = tapph_pkg::CFG_DATA_W'(ground_thr_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign accept         = in_ch.valid && in_ch.ready;
  assign load           = (state_r == ST_DONE) && free;
  assign lane_ctl.start = accept;
  assign lane_ctl.clear = (in_ch.distance <= ground_thr_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          cnt_nxt   = tapph_pkg::CNT_W'(tapph_pkg::LANE_STAGES - 1);
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == tapph_pkg::CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  tapph_lane #(.DISP_WIDTH(DISP_WIDTH)) u_lane_x (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (lane_ctl),
    .gains       (gains_x_r),
    .integ_limit (integ_limit_r),
    .disp        (in_ch.disp_x),
    .angle       (angle_x),
    .delta       (delta_x)
  );

  tapph_lane #(.DISP_WIDTH(DISP_WIDTH)) u_lane_y (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (lane_ctl),
    .gains       (gains_y_r),
    .integ_limit (integ_limit_r),
    .disp        (in_ch.disp_y),
    .angle       (angle_y),
    .delta       (delta_y)
  );

  tapph_merge #(.DISP_WIDTH(DISP_WIDTH)) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .free    (free),
    .angle_x (angle_x),
    .angle_y (angle_y),
    .delta_x (delta_x),
    .delta_y (delta_y),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/tapph_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapph_lane
// One axis: clamped integrator, difference, PID products and saturation.
// ----------------------------------------------------------------------------
module tapph_lane #(
  parameter int DISP_WIDTH = tapph_pkg::DISP_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tapph_pkg::lane_ctl_t                ctl,
  input  tapph_pkg::lane_gains_t              gains,
  input  logic [tapph_pkg::LIM_W-1:0]         integ_limit,
  input  logic signed [DISP_WIDTH-1:0]        disp,
  output logic signed [tapph_pkg::ANGLE_W-1:0] angle,
  output logic signed [DISP_WIDTH:0]          delta
);

  localparam int IW    = tapph_pkg::INTEG_W;
  localparam int GW    = tapph_pkg::GAIN_W;
  localparam int AW    = tapph_pkg::ACC_W;
  localparam int QW    = tapph_pkg::ANGLE_W;
  localparam int SUM_W = ((IW > DISP_WIDTH) ? IW : DISP_WIDTH) + 1;
  localparam int DW    = DISP_WIDTH + 1;
  localparam int PD_W  = GW + DW;
  localparam int PI_W  = GW + IW;
  localparam int EXT_W = (PD_W > AW) ? PD_W : AW;

  logic signed [IW-1:0]         integ_r;
  logic signed [DISP_WIDTH-1:0] prev_r;
  logic signed [IW-1:0]         s1_integ_r;
  logic signed [DISP_WIDTH-1:0] s1_disp_r;
  logic signed [DW-1:0]         delta_r;
  logic signed [PD_W-1:0]       s2_pd_r;
  logic signed [PI_W-1:0]       s2_pi_r;
  logic signed [DISP_WIDTH-1:0] s2_disp_r;
  logic signed [AW-1:0]         s3_pd_r;
  logic signed [PI_W-1:0]       s3_pi_r;
  logic signed [DISP_WIDTH-1:0] s3_disp_r;
  logic signed [AW-1:0]         s4_acc_r;
  logic signed [GW-1:0]         s5_inner_r;
  logic signed [AW-1:0]         s6_prod_r;
  logic signed [QW-1:0]         s7_angle_r;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lim;
  logic signed [IW-1:0]     integ_nxt;
  logic signed [DW-1:0]     delta_nxt;
  logic signed [EXT_W-1:0]  pd_ext;
  logic signed [AW-1:0]     pd_sat;
  logic signed [AW-1:0]     acc_rnd;
  logic signed [AW-1:0]     acc_sh;
  logic signed [GW-1:0]     inner_nxt;
  logic signed [AW-1:0]     ang_rnd;
  logic signed [AW-1:0]     ang_sh;
  logic signed [QW-1:0]     angle_nxt;

  always_comb begin
    sum = SUM_W'(integ_r) + SUM_W'(disp);
    lim = SUM_W'($signed({1'b0, integ_limit, 8'h00}));
    if (sum > lim) begin
      integ_nxt = IW'(lim);
    end else if (sum < -lim) begin
      integ_nxt = IW'(-lim);
    end else begin
      integ_nxt = IW'(sum);
    end
    delta_nxt = DW'(disp) - DW'(prev_r);
  end

  always_comb begin
    pd_ext = EXT_W'(s2_pd_r);
    if (pd_ext > EXT_W'(tapph_pkg::ACC_CLAMP)) begin
      pd_sat = tapph_pkg::ACC_CLAMP;
    end else if (pd_ext < -EXT_W'(tapph_pkg::ACC_CLAMP)) begin
      pd_sat = -tapph_pkg::ACC_CLAMP;
    end else begin
      pd_sat = AW'(pd_ext);
    end
  end

  always_comb begin
    acc_rnd = s4_acc_r + tapph_pkg::ROUND_HALF;
    acc_sh  = acc_rnd >>> tapph_pkg::FRAC_SHIFT;
    if (acc_sh > tapph_pkg::INNER_MAX) begin
      inner_nxt = GW'(tapph_pkg::INNER_MAX);
    end else if (acc_sh < tapph_pkg::INNER_MIN) begin
      inner_nxt = GW'(tapph_pkg::INNER_MIN);
    end else begin
      inner_nxt = GW'(acc_sh);
    end
  end

  always_comb begin
    ang_rnd = s6_prod_r + tapph_pkg::ROUND_HALF;
    ang_sh  = ang_rnd >>> tapph_pkg::FRAC_SHIFT;
    if (ang_sh > AW'(tapph_pkg::ANGLE_MAX)) begin
      angle_nxt = QW'(tapph_pkg::ANGLE_MAX);
    end else if (ang_sh < -AW'(tapph_pkg::ANGLE_MAX)) begin
      angle_nxt = QW'(-tapph_pkg::ANGLE_MAX);
    end else begin
      angle_nxt = QW'(ang_sh);
    end
  end

  // state update folds in the ground clear; the result uses the old state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (ctl.start) begin
      integ_r <= ctl.clear ? '0 : integ_nxt;
      prev_r  <= ctl.clear ? '0 : disp;
    end
  end

  // hold the first stage; later stages settle and stay while it holds
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      s1_integ_r <= integ_nxt;
      s1_disp_r  <= disp;
      delta_r    <= delta_nxt;
    end
    s2_pd_r    <= PD_W'(gains.d) * PD_W'(delta_r);
    s2_pi_r    <= PI_W'(gains.i) * PI_W'(s1_integ_r);
    s2_disp_r  <= s1_disp_r;
    s3_pd_r    <= pd_sat;
    s3_pi_r    <= s2_pi_r;
    s3_disp_r  <= s2_disp_r;
    s4_acc_r   <= s3_pd_r + AW'(s3_pi_r) + (AW'(s3_disp_r) <<< tapph_pkg::FRAC_SHIFT);
    s5_inner_r <= inner_nxt;
    s6_prod_r  <= AW'(gains.p) * AW'(s5_inner_r);
    s7_angle_r <= angle_nxt;
  end

  assign angle = s7_angle_r;
  assign delta = delta_r;

endmodule

// ===== rtl/tapph_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapph_merge
// Combine both lane results into one result transfer and hold it.
// ----------------------------------------------------------------------------
module tapph_merge #(
  parameter int DISP_WIDTH = tapph_pkg::DISP_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  output logic                                 free,
  input  logic signed [tapph_pkg::ANGLE_W-1:0] angle_x,
  input  logic signed [tapph_pkg::ANGLE_W-1:0] angle_y,
  input  logic signed [DISP_WIDTH:0]           delta_x,
  input  logic signed [DISP_WIDTH:0]           delta_y,
  tapph_out_if.source                          out_ch
);

  logic                                 valid_r;
  logic signed [tapph_pkg::ANGLE_W-1:0] angle_x_r;
  logic signed [tapph_pkg::ANGLE_W-1:0] angle_y_r;
  logic signed [DISP_WIDTH:0]           delta_x_r;
  logic signed [DISP_WIDTH:0]           delta_y_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      angle_x_r <= angle_x;
      angle_y_r <= angle_y;
      delta_x_r <= delta_x;
      delta_y_r <= delta_y;
    end
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.angle_x = angle_x_r;
  assign out_ch.angle_y = angle_y_r;
  assign out_ch.delta_x = delta_x_r;
  assign out_ch.delta_y = delta_y_r;

endmodule

// ===== rtl/tapph_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapph_chk
// Port-level checks of the position-hold controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tapph_chk (
  input logic         clk,
  input logic         rst_n,
  tapph_in_if.sink    in_ch,
  tapph_out_if.source out_ch
);

  logic angle_x_ok;
  logic angle_y_ok;

  assign angle_x_ok = (int'(out_ch.angle_x) <= tapph_pkg::ANGLE_MAX) &&
                      (int'(out_ch.angle_x) >= -tapph_pkg::ANGLE_MAX);
  assign angle_y_ok = (int'(out_ch.angle_y) <= tapph_pkg::ANGLE_MAX) &&
                      (int'(out_ch.angle_y) >= -tapph_pkg::ANGLE_MAX);

  `TAPPH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
  `TAPPH_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `TAPPH_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_ch.valid && in_ch.ready, !$rose(out_ch.valid))
  `TAPPH_ASSERT_NOW(a_angle_x_range, clk, rst_n, out_ch.valid, angle_x_ok)
  `TAPPH_ASSERT_NOW(a_angle_y_range, clk, rst_n, out_ch.valid, angle_y_ok)

endmodule

bind two_axis_position_hold_pid_unit tapph_chk u_tapph_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
